// ===== rtl/core/pqga_pkg.sv =====
// Package for the grant allocator: field widths, register indexes and control types.
`timescale 1ns / 1ps
package pqga_pkg;

	localparam int TermW  = 10;
	localparam int QueueW = 24;
	localparam int TimeW  = 48;
	localparam int GrantW = 16;
	localparam int WeightW = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam int DivSteps = 24;
	localparam int DivCntW  = 5;

	localparam logic [CfgIdxW-1:0] CFG_MAX_GRANT    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_WEIGHT_BB    = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_WEIGHT_MC    = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_GUARD        = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_B  = 3'd4;

	localparam logic [GrantW-1:0]  RST_MAX_GRANT   = 16'd15000;
	localparam logic [WeightW-1:0] RST_WEIGHT      = 8'd1;
	localparam logic [GrantW-1:0]  RST_GUARD       = 16'd0;
	localparam logic [WeightW-1:0] RST_TICKS_PER_B = 8'd1;

	localparam logic [GrantW-1:0] MIN_GRANT_BYTES = 16'd64;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic share1;
		logic share2;
		logic share3;
		logic total;
		logic finish;
	} pqga_cmd_t;

	typedef struct packed {
		logic out_stall;
	} pqga_status_t;

endpackage

// ===== rtl/core/pqga_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module pqga_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output pqga_pkg::pqga_cmd_t    cmd,
	input  pqga_pkg::pqga_status_t st
);
	import pqga_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SH1  = 3'd3;
	localparam logic [2:0] ST_SH2  = 3'd4;
	localparam logic [2:0] ST_SH3  = 3'd5;
	localparam logic [2:0] ST_TOT  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]         state_q;
	logic [2:0]         state_d;
	logic [DivCntW-1:0] cnt_q;
	logic               div_last;

	assign in_ready = (state_q == ST_IDLE);
	assign div_last = (cnt_q == DivCntW'(DivSteps - 1));

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) state_d = ST_SH1;
			end
			ST_SH1: begin
				cmd.share1 = 1'b1;
				state_d    = ST_SH2;
			end
			ST_SH2: begin
				cmd.share2 = 1'b1;
				state_d    = ST_SH3;
			end
			ST_SH3: begin
				cmd.share3 = 1'b1;
				state_d    = ST_TOT;
			end
			ST_TOT: begin
				cmd.total = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the item
				if (!st.out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else                   cnt_q <= '0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL))
		else $error("accepted item did not start the multiply step");
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_last) |=> (state_q == ST_SH1))
		else $error("divider did not end after its last step");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |=> (cnt_q == '0))
		else $error("divide step counter not cleared outside division");

endmodule

// ===== rtl/core/pqga_dp.sv =====
// Datapath: configuration registers, urgent grant, serial divider, sharing and start time.
`timescale 1ns / 1ps
module pqga_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pqga_pkg::pqga_cmd_t                cmd,
	output pqga_pkg::pqga_status_t             st,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pqga_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [pqga_pkg::CfgDataW-1:0]     cfg_data,
	input  logic [pqga_pkg::TermW-1:0]        terminal_id,
	input  logic [pqga_pkg::QueueW-1:0]       queue_urgent,
	input  logic [pqga_pkg::QueueW-1:0]       queue_broadband,
	input  logic [pqga_pkg::QueueW-1:0]       queue_machine,
	input  logic                              first_of_cycle,
	input  logic [pqga_pkg::TimeW-1:0]        cycle_start_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pqga_pkg::TermW-1:0]        grant_terminal,
	output logic [pqga_pkg::TimeW-1:0]        grant_start,
	output logic [pqga_pkg::GrantW-1:0]       grant_urgent,
	output logic [pqga_pkg::GrantW-1:0]       grant_broadband,
	output logic [pqga_pkg::GrantW-1:0]       grant_machine
);
	import pqga_pkg::*;

	function automatic logic [QueueW-1:0] min_q(input logic [QueueW-1:0] a,
	                                            input logic [QueueW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// configuration
	logic [GrantW-1:0]  max_grant_q;
	logic [WeightW-1:0] w_bb_q;
	logic [WeightW-1:0] w_mc_q;
	logic [GrantW-1:0]  guard_q;
	logic [WeightW-1:0] tpb_q;

	// working registers
	logic [TermW-1:0]   term_q;
	logic [QueueW-1:0]  q_bb_q;
	logic [QueueW-1:0]  q_mc_q;
	logic [GrantW-1:0]  g_urg_q;
	logic [GrantW-1:0]  rest_q;
	logic [QueueW-1:0]  dvd_q;
	logic [9:0]         rem_q;
	logic [GrantW-1:0]  ideal_bb_q;
	logic [GrantW-1:0]  ideal_mc_q;
	logic [GrantW-1:0]  g_bb_q;
	logic [GrantW-1:0]  g_mc_q;
	logic [24:0]        tprod_q;
	logic [TimeW-1:0]   rt_q;
	logic               out_valid_q;

	logic [WeightW:0]   wsum;
	logic [9:0]         rem_sh;
	logic               rem_ge;
	logic [GrantW-1:0]  urg_min;
	logic [GrantW-1:0]  ideal_bb;
	logic [GrantW-1:0]  ideal_mc;
	logic [GrantW:0]    mc_topup;
	logic [GrantW:0]    bb_topup;
	logic               g_zero;
	logic [GrantW-1:0]  mc_final;
	logic [GrantW+1:0]  total;

	assign cfg_ready = 1'b1;
	assign st.out_stall = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;

	assign wsum    = {1'b0, w_bb_q} + {1'b0, w_mc_q};
	assign rem_sh  = {rem_q[8:0], dvd_q[QueueW-1]};
	assign rem_ge  = (rem_sh >= {1'b0, wsum});
	assign urg_min = GrantW'(min_q(queue_urgent, QueueW'(max_grant_q)));

	// zero weight sum leaves the whole rest to the machine class
	assign ideal_bb = (wsum == '0) ? '0 : dvd_q[GrantW-1:0];
	assign ideal_mc = rest_q - ideal_bb;

	assign mc_topup = {1'b0, g_mc_q} + {1'b0, ideal_bb_q} - {1'b0, g_bb_q};
	assign bb_topup = {1'b0, g_bb_q} + {1'b0, ideal_mc_q} - {1'b0, g_mc_q};

	assign g_zero   = (g_urg_q == '0) && (g_bb_q == '0) && (g_mc_q == '0);
	assign mc_final = g_zero ? MIN_GRANT_BYTES : g_mc_q;
	assign total    = {2'b0, g_urg_q} + {2'b0, g_bb_q} + {2'b0, mc_final};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_grant_q <= RST_MAX_GRANT;
			w_bb_q      <= RST_WEIGHT;
			w_mc_q      <= RST_WEIGHT;
			guard_q     <= RST_GUARD;
			tpb_q       <= RST_TICKS_PER_B;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_GRANT:   max_grant_q <= cfg_data;
				CFG_WEIGHT_BB:   w_bb_q      <= cfg_data[WeightW-1:0];
				CFG_WEIGHT_MC:   w_mc_q      <= cfg_data[WeightW-1:0];
				CFG_GUARD:       guard_q     <= cfg_data;
				CFG_TICKS_PER_B: tpb_q       <= cfg_data[WeightW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && first_of_cycle) rt_q <= cycle_start_time;
			else if (cmd.finish) rt_q <= rt_q + TimeW'(tprod_q) + TimeW'(guard_q);
			if (cmd.finish)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			term_q  <= terminal_id;
			q_bb_q  <= queue_broadband;
			q_mc_q  <= queue_machine;
			g_urg_q <= urg_min;
			rest_q  <= max_grant_q - urg_min;
		end
		if (cmd.mul) begin
			dvd_q <= QueueW'(rest_q * w_bb_q);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring division, one quotient bit per step
			rem_q <= rem_ge ? (rem_sh - {1'b0, wsum}) : rem_sh;
			dvd_q <= {dvd_q[QueueW-2:0], rem_ge};
		end
		if (cmd.share1) begin
			ideal_bb_q <= ideal_bb;
			ideal_mc_q <= ideal_mc;
			g_bb_q     <= GrantW'(min_q(q_bb_q, QueueW'(ideal_bb)));
			g_mc_q     <= GrantW'(min_q(q_mc_q, QueueW'(ideal_mc)));
		end
		// pass unused broadband share to machine
		if (cmd.share2 && (ideal_bb_q > g_bb_q))
			g_mc_q <= GrantW'(min_q(q_mc_q, QueueW'(mc_topup)));
		// pass unused machine share back to broadband
		if (cmd.share3 && (ideal_mc_q > g_mc_q))
			g_bb_q <= GrantW'(min_q(q_bb_q, QueueW'(bb_topup)));
		if (cmd.total) begin
			g_mc_q  <= mc_final;
			tprod_q <= 25'(total * tpb_q);
		end
		if (cmd.finish) begin
			grant_terminal  <= term_q;
			grant_start     <= rt_q;
			grant_urgent    <= g_urg_q;
			grant_broadband <= g_bb_q;
			grant_machine   <= g_mc_q;
		end
	end

	a_ideal_in_rest: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.share1 |-> (ideal_bb <= rest_q))
		else $error("broadband share exceeds remaining budget");
	a_grant_budget: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (({2'b0, grant_urgent} + {2'b0, grant_broadband}
			+ {2'b0, grant_machine} <= {2'b0, max_grant_q})
			|| (grant_urgent == '0 && grant_broadband == '0
			&& grant_machine == MIN_GRANT_BYTES)))
		else $error("grant exceeds byte budget");
	a_urgent_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.share1 |-> (g_urg_q + rest_q == max_grant_q))
		else $error("urgent grant and rest do not add up to the budget");

endmodule

// ===== rtl/core/pon_qos_grant_allocator_unit.sv =====
// Top level of the upstream grant allocator: controller plus datapath.
// Sequence per accepted item: multiply, the 24-step serial divider, the sharing steps, total,
// then a wait until the output register is free; a new item is accepted only back in idle.
// The next item may be accepted while the previous result waits in the output register.
// Reset: configuration returns to its defaults and the running start time to zero.
`timescale 1ns / 1ps
module pon_qos_grant_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pqga_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pqga_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pqga_pkg::TermW-1:0]    terminal_id,
	input  logic [pqga_pkg::QueueW-1:0]   queue_urgent,
	input  logic [pqga_pkg::QueueW-1:0]   queue_broadband,
	input  logic [pqga_pkg::QueueW-1:0]   queue_machine,
	input  logic                          first_of_cycle,
	input  logic [pqga_pkg::TimeW-1:0]    cycle_start_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pqga_pkg::TermW-1:0]    grant_terminal,
	output logic [pqga_pkg::TimeW-1:0]    grant_start,
	output logic [pqga_pkg::GrantW-1:0]   grant_urgent,
	output logic [pqga_pkg::GrantW-1:0]   grant_broadband,
	output logic [pqga_pkg::GrantW-1:0]   grant_machine
);
	import pqga_pkg::*;

	pqga_cmd_t    cmd;
	pqga_status_t st;

	pqga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	pqga_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.terminal_id      (terminal_id),
		.queue_urgent     (queue_urgent),
		.queue_broadband  (queue_broadband),
		.queue_machine    (queue_machine),
		.first_of_cycle   (first_of_cycle),
		.cycle_start_time (cycle_start_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.grant_terminal   (grant_terminal),
		.grant_start      (grant_start),
		.grant_urgent     (grant_urgent),
		.grant_broadband  (grant_broadband),
		.grant_machine    (grant_machine)
	);

endmodule
